// ===== hdl/mseq_pkg.sv =====
// ----------------------------------------------------------------------------
// mseq_pkg
// Types and constants shared by the marker sequence frame checker.
// ----------------------------------------------------------------------------
package mseq_pkg;

  localparam int unsigned MARKER_LEN = 4;

  localparam logic [7:0]  MARKER_RESET = 8'd42;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd4000;

  localparam int unsigned PADDR_W = 3;

  // register byte addresses, bit 2 selects the register
  typedef enum logic [0:0] {
    REG_MARKER     = 1'b0,
    REG_IDLE_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_SYNC    = 3'd2,
    EV_SEQERR  = 3'd3,
    EV_BADBYTE = 3'd4,
    EV_RESET   = 3'd5
  } event_t;

  typedef enum logic {
    PH_HUNT   = 1'b0,
    PH_NUMBER = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0]  marker_value;
    logic [15:0] idle_limit_ticks;
  } cfg_t;

  typedef struct packed {
    event_t      event_res;
    logic [31:0] good_total;
    logic [31:0] bad_total;
    logic [31:0] expected_base;
    logic        in_sync;
  } res_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== hdl/mseq_cfg.sv =====
// ----------------------------------------------------------------------------
// mseq_cfg
// APB register file: marker byte value and idle tick limit.
// ----------------------------------------------------------------------------
module mseq_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mseq_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output mseq_pkg::cfg_t                 cfg
);

  logic            wr_en;
  mseq_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = mseq_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_value     <= mseq_pkg::MARKER_RESET;
      cfg.idle_limit_ticks <= mseq_pkg::IDLE_LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        mseq_pkg::REG_MARKER:     cfg.marker_value     <= pwdata[7:0];
        mseq_pkg::REG_IDLE_LIMIT: cfg.idle_limit_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mseq_pkg::REG_MARKER:     prdata = {24'd0, cfg.marker_value};
      mseq_pkg::REG_IDLE_LIMIT: prdata = {16'd0, cfg.idle_limit_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/mseq_core.sv =====
// ----------------------------------------------------------------------------
// mseq_core
// Frame parser, sequence check, saturating counters and idle timeout.
// ----------------------------------------------------------------------------
module mseq_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           op,
  input  logic [7:0]     rx_byte,
  input  mseq_pkg::cfg_t cfg,
  output mseq_pkg::res_t res
);

  mseq_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [31:0] number_assembly, number_assembly_next;
  logic [31:0] previous_number, previous_number_next;
  logic        sync_held, sync_held_next;
  logic [31:0] good_frames, good_frames_next;
  logic [31:0] bad_events, bad_events_next;
  logic [15:0] idle_count, idle_count_next;
  logic        data_seen, data_seen_next;
  mseq_pkg::event_t ev;

  logic [2:0]  pos_inc;
  logic [31:0] assembled;
  logic [15:0] idle_inc;

  assign pos_inc  = byte_position + 3'd1;
  assign idle_inc = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;

  always_comb begin
    case (byte_position[1:0])
      2'd0:    assembled = number_assembly | {24'd0, rx_byte};
      2'd1:    assembled = number_assembly | {16'd0, rx_byte, 8'd0};
      2'd2:    assembled = number_assembly | {8'd0, rx_byte, 16'd0};
      default: assembled = number_assembly | {rx_byte, 24'd0};
    endcase
  end

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    number_assembly_next = number_assembly;
    previous_number_next = previous_number;
    sync_held_next       = sync_held;
    good_frames_next     = good_frames;
    bad_events_next      = bad_events;
    idle_count_next      = idle_count;
    data_seen_next       = data_seen;
    ev                   = mseq_pkg::EV_NONE;

    if (!op) begin
      data_seen_next  = 1'b1;
      idle_count_next = 16'd0;
      if (phase == mseq_pkg::PH_HUNT) begin
        if (rx_byte == cfg.marker_value) begin
          byte_position_next = pos_inc;
          if (pos_inc >= 3'(mseq_pkg::MARKER_LEN)) begin
            phase_next           = mseq_pkg::PH_NUMBER;
            byte_position_next   = 3'd0;
            number_assembly_next = 32'd0;
          end
        end else begin
          bad_events_next    = mseq_pkg::sat_inc32(bad_events);
          byte_position_next = 3'd0;
          ev                 = mseq_pkg::EV_BADBYTE;
        end
      end else begin
        number_assembly_next = assembled;
        byte_position_next   = pos_inc;
        if (pos_inc >= 3'd4) begin
          if (sync_held) begin
            if (assembled == previous_number + 32'd1) begin
              good_frames_next     = mseq_pkg::sat_inc32(good_frames);
              previous_number_next = assembled;
              ev                   = mseq_pkg::EV_GOOD;
            end else begin
              sync_held_next  = 1'b0;
              bad_events_next = mseq_pkg::sat_inc32(bad_events);
              ev              = mseq_pkg::EV_SEQERR;
            end
          end else begin
            previous_number_next = assembled;
            sync_held_next       = 1'b1;
            ev                   = mseq_pkg::EV_SYNC;
          end
          phase_next           = mseq_pkg::PH_HUNT;
          byte_position_next   = 3'd0;
          number_assembly_next = 32'd0;
        end
      end
    end else if (data_seen) begin
      idle_count_next = idle_inc;
      if (idle_inc >= cfg.idle_limit_ticks) begin
        good_frames_next     = 32'd0;
        bad_events_next      = 32'd0;
        sync_held_next       = 1'b0;
        data_seen_next       = 1'b0;
        idle_count_next      = 16'd0;
        phase_next           = mseq_pkg::PH_HUNT;
        byte_position_next   = 3'd0;
        number_assembly_next = 32'd0;
        ev                   = mseq_pkg::EV_RESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mseq_pkg::PH_HUNT;
      byte_position   <= 3'd0;
      number_assembly <= 32'd0;
      previous_number <= 32'd0;
      sync_held       <= 1'b0;
      good_frames     <= 32'd0;
      bad_events      <= 32'd0;
      idle_count      <= 16'd0;
      data_seen       <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      number_assembly <= number_assembly_next;
      previous_number <= previous_number_next;
      sync_held       <= sync_held_next;
      good_frames     <= good_frames_next;
      bad_events      <= bad_events_next;
      idle_count      <= idle_count_next;
      data_seen       <= data_seen_next;
    end
  end

  // result for the transaction being accepted, state after the step
  assign res.event_res     = ev;
  assign res.good_total    = good_frames_next;
  assign res.bad_total     = bad_events_next;
  assign res.expected_base = previous_number_next;
  assign res.in_sync       = sync_held_next;

endmodule

// ===== hdl/mseq_obuf.sv =====
// ----------------------------------------------------------------------------
// mseq_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module mseq_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mseq_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output mseq_pkg::res_t out_data
);

  logic           skid_valid;
  mseq_pkg::res_t skid_data;
  logic           pop;

  assign full = skid_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no push can arrive while the skid entry is held
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== hdl/marker_sequence_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// marker_sequence_frame_checker_core
// Marker and sequence-number frame checker with stream ports and APB config.
// ----------------------------------------------------------------------------
// Each input transaction is a received byte (s_tuser = 0) or one idle tick
// (s_tuser = 1) and produces exactly one result transaction. One item is
// accepted every cycle while s_tready is high; the parser state updates in a
// single pass and the result lands in a two-entry output buffer, so s_tready
// drops only when both buffer entries are held by a stalled m_tready.
// Registers: 0x0 marker_value (8 bits), 0x4 idle_limit_ticks (16 bits).
// Write configuration only while no transaction is in flight.
module marker_sequence_frame_checker_core (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: [7:0] rx_byte
  input  logic [7:0]                   s_tdata,
  // s_tuser: [0] op
  input  logic                         s_tuser,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // m_tdata: [31:0] good_total, [63:32] bad_total, [95:64] expected_base,
  //          [96] in_sync, [103:97] zero
  output logic [103:0]                 m_tdata,
  // m_tuser: [2:0] event_res
  output logic [2:0]                   m_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mseq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  mseq_pkg::cfg_t cfg;
  mseq_pkg::res_t res;
  mseq_pkg::res_t out_res;
  logic           accept;
  logic           full;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  mseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mseq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (s_tuser),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  mseq_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tuser = out_res.event_res;
  assign m_tdata = {7'd0, out_res.in_sync, out_res.expected_base,
                    out_res.bad_total, out_res.good_total};

endmodule
